// ===== rtl/exti_pkg.sv =====
// ----------------------------------------------------------------------------
// exti_pkg
// Shared types and constants for the external interrupt line controller.
// ----------------------------------------------------------------------------
package exti_pkg;

    // Width of every per-line field on the ports and in the register file
    localparam int FIELD_W = 23;

    // Lines 19 and 20 have no logic behind them
    localparam logic [FIELD_W-1:0] HOLE_MASK = FIELD_W'((1 << 19) | (1 << 20));

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2
    } req_type_t;

    typedef enum logic [2:0] {
        ADDR_IMASK   = 3'd0,
        ADDR_EMASK   = 3'd1,
        ADDR_RISE    = 3'd2,
        ADDR_FALL    = 3'd3,
        ADDR_SWTRIG  = 3'd4,
        ADDR_PENDING = 3'd5
    } reg_addr_t;

    // Architectural state of the controller
    typedef struct packed {
        logic [FIELD_W-1:0] int_mask;
        logic [FIELD_W-1:0] event_mask;
        logic [FIELD_W-1:0] rise_select;
        logic [FIELD_W-1:0] fall_select;
        logic [FIELD_W-1:0] soft_trigger;
        logic [FIELD_W-1:0] pending;
        logic [FIELD_W-1:0] last_levels;
    } exti_state_t;

    // Result of one beat
    typedef struct packed {
        logic [FIELD_W-1:0] read_data;
        logic [FIELD_W-1:0] irq_lines;
        logic [FIELD_W-1:0] event_pulses;
        logic               addr_error;
    } exti_result_t;

    // Bits of lines that exist for a given line count
    function automatic logic [FIELD_W-1:0] impl_mask(input int num_lines);
        logic [FIELD_W-1:0] m;
        m = '0;
        for (int i = 0; i < FIELD_W; i++) begin
            m[i] = (i < num_lines);
        end
        return m & ~HOLE_MASK;
    endfunction

endpackage

// ===== rtl/external_interrupt_line_controller_unit.sv =====
// ----------------------------------------------------------------------------
// external_interrupt_line_controller_unit
// External interrupt controller: masks, edge selects, soft trigger, pending.
// ----------------------------------------------------------------------------
// Each input beat is a pin-sample tick, a register write or a register read,
// and gives exactly one result beat. A beat is captured in an input register,
// then the line logic updates the register file and loads the result
// register, so the block takes one beat per clock unless the result register
// is full and m_ready is low, which holds the beat in the input register.
// Both stages advance together when the result register is empty or being
// drained, so s_ready follows m_ready through one gate.
// Lines 19, 20 and any at or above NUM_LINES read zero and ignore writes.
// m_irq_lines is pending & int_mask after the beat; m_event_pulses flags
// lines whose selected edge or fresh soft trigger hit an unmasked event line.
module external_interrupt_line_controller_unit #(
    parameter int NUM_LINES = 23
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_req_type,
    input  logic [2:0]                   s_reg_addr,
    input  logic [exti_pkg::FIELD_W-1:0] s_write_data,
    input  logic [exti_pkg::FIELD_W-1:0] s_pin_levels,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [exti_pkg::FIELD_W-1:0] m_read_data,
    output logic [exti_pkg::FIELD_W-1:0] m_irq_lines,
    output logic [exti_pkg::FIELD_W-1:0] m_event_pulses,
    output logic                         m_addr_error
);
    import exti_pkg::*;

    localparam logic [FIELD_W-1:0] IMPL_MASK = impl_mask(NUM_LINES);

    // input stage
    logic               in_valid_reg;
    logic [1:0]         in_req_type_reg;
    logic [2:0]         in_reg_addr_reg;
    logic [FIELD_W-1:0] in_write_data_reg;
    logic [FIELD_W-1:0] in_pin_levels_reg;

    // result stage
    logic               out_valid_reg;
    exti_result_t       out_reg;

    // register file
    exti_state_t        st_reg;
    exti_state_t        st_next;
    exti_result_t       result;

    logic               advance;

    // process the held beat when the result slot frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    exti_core #(
        .IMPL_MASK (IMPL_MASK)
    ) u_core (
        .req_type   (in_req_type_reg),
        .reg_addr   (in_reg_addr_reg),
        .write_data (in_write_data_reg),
        .pin_levels (in_pin_levels_reg),
        .st_cur     (st_reg),
        .st_next    (st_next),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_type_reg   <= s_req_type;
            in_reg_addr_reg   <= s_reg_addr;
            in_write_data_reg <= s_write_data;
            in_pin_levels_reg <= s_pin_levels;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_read_data    = out_reg.read_data;
    assign m_irq_lines    = out_reg.irq_lines;
    assign m_event_pulses = out_reg.event_pulses;
    assign m_addr_error   = out_reg.addr_error;

    // unimplemented lines never hold a pending or soft trigger bit
    a_no_stray_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        ((st_reg.pending | st_reg.soft_trigger) & ~IMPL_MASK) == '0)
        else $error("pending or soft trigger set on an unimplemented line");

    // reported irq lines match the register file right after the update
    a_irq_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_irq_lines == (st_reg.pending & st_reg.int_mask)))
        else $error("irq lines disagree with pending and mask");

    // read data is zero unless the beat was a read
    a_rdata_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_req_type_reg != REQ_READ)) |=> (m_read_data == '0))
        else $error("read data on a non-read beat");

    // an address error never comes with event pulses
    a_err_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_addr_error) |-> (m_event_pulses == '0))
        else $error("event pulse on a bad address");

endmodule

// ===== rtl/exti_core.sv =====
// ----------------------------------------------------------------------------
// exti_core
// Per-line update logic for one beat: edge detect, register access, results.
// ----------------------------------------------------------------------------
module exti_core #(
    parameter logic [22:0] IMPL_MASK = 23'h67FFFF
) (
    input  logic [1:0]                   req_type,
    input  logic [2:0]                   reg_addr,
    input  logic [exti_pkg::FIELD_W-1:0] write_data,
    input  logic [exti_pkg::FIELD_W-1:0] pin_levels,
    input  exti_pkg::exti_state_t        st_cur,
    output exti_pkg::exti_state_t        st_next,
    output exti_pkg::exti_result_t       result
);
    import exti_pkg::*;

    logic [FIELD_W-1:0] data;
    logic [FIELD_W-1:0] pins;
    logic [FIELD_W-1:0] hit;
    logic [FIELD_W-1:0] fresh;
    logic [FIELD_W-1:0] rdata;
    logic [FIELD_W-1:0] events;
    logic               err;

    assign data  = write_data & IMPL_MASK;
    assign pins  = pin_levels & IMPL_MASK;
    assign hit   = (((~st_cur.last_levels) & pins & st_cur.rise_select)
                   | (st_cur.last_levels & ~pins & st_cur.fall_select)) & IMPL_MASK;
    assign fresh = data & ~st_cur.soft_trigger;

    always_comb begin
        st_next = st_cur;
        rdata   = '0;
        events  = '0;
        err     = 1'b0;
        case (req_type_t'(req_type))
            REQ_TICK: begin
                st_next.pending     = st_cur.pending | (hit & st_cur.int_mask);
                st_next.last_levels = pins;
                events              = hit & st_cur.event_mask;
            end
            REQ_WRITE: begin
                case (reg_addr_t'(reg_addr))
                    ADDR_IMASK:  st_next.int_mask    = data;
                    ADDR_EMASK:  st_next.event_mask  = data;
                    ADDR_RISE:   st_next.rise_select = data;
                    ADDR_FALL:   st_next.fall_select = data;
                    ADDR_SWTRIG: begin
                        // only 0-to-1 transitions fire
                        st_next.pending      = st_cur.pending | (fresh & st_cur.int_mask);
                        st_next.soft_trigger = st_cur.soft_trigger | data;
                        events               = fresh & st_cur.event_mask;
                    end
                    ADDR_PENDING: begin
                        // write-one-to-clear, also drops the soft trigger
                        st_next.pending      = st_cur.pending & ~data;
                        st_next.soft_trigger = st_cur.soft_trigger & ~data;
                    end
                    default: err = 1'b1;
                endcase
            end
            REQ_READ: begin
                case (reg_addr_t'(reg_addr))
                    ADDR_IMASK:   rdata = st_cur.int_mask;
                    ADDR_EMASK:   rdata = st_cur.event_mask;
                    ADDR_RISE:    rdata = st_cur.rise_select;
                    ADDR_FALL:    rdata = st_cur.fall_select;
                    ADDR_SWTRIG:  rdata = st_cur.soft_trigger;
                    ADDR_PENDING: rdata = st_cur.pending;
                    default:      err   = 1'b1;
                endcase
            end
            default: ;  // reserved request: idle beat
        endcase
    end

    always_comb begin
        result.read_data    = rdata;
        result.irq_lines    = st_next.pending & st_next.int_mask;
        result.event_pulses = events;
        result.addr_error   = err;
    end

endmodule

// ===== verif/exti_beat_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exti_beat_checker
// Watches both channels of the interrupt controller, keeps its own copy of the
// register file, predicts one result per accepted input beat and compares
// every result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module exti_beat_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [1:0]                   s_req_type,
    input  logic [2:0]                   s_reg_addr,
    input  logic [exti_pkg::FIELD_W-1:0] s_write_data,
    input  logic [exti_pkg::FIELD_W-1:0] s_pin_levels,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [exti_pkg::FIELD_W-1:0] m_read_data,
    input  logic [exti_pkg::FIELD_W-1:0] m_irq_lines,
    input  logic [exti_pkg::FIELD_W-1:0] m_event_pulses,
    input  logic                         m_addr_error,
    output int                           mismatch_count,
    output int                           results_owed
);
    import exti_pkg::*;

    // All 23 lines exist except the two holes
    localparam logic [FIELD_W-1:0] LIVE_LINES = ~HOLE_MASK;
    localparam int PRINT_CAP = 100;

    exti_state_t  regs;
    exti_result_t results_due[$];

    task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                   input logic [FIELD_W-1:0] want);
        if (mismatch_count < PRINT_CAP) begin
            $display("%0t ERROR %s: got %06h want %06h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // Advances the register copy by one beat and returns the result it gives
    function automatic exti_result_t apply_beat(input logic [1:0] kind,
                                                input logic [2:0] addr,
                                                input logic [FIELD_W-1:0] wdata,
                                                input logic [FIELD_W-1:0] pins);
        exti_result_t       r;
        logic [FIELD_W-1:0] d;
        logic [FIELD_W-1:0] p;
        logic [FIELD_W-1:0] hit;
        logic [FIELD_W-1:0] fresh;
        r = '0;
        d = wdata & LIVE_LINES;
        p = pins & LIVE_LINES;
        case (kind)
            REQ_TICK: begin
                hit = ((~regs.last_levels & p & regs.rise_select)
                      | (regs.last_levels & ~p & regs.fall_select)) & LIVE_LINES;
                regs.pending = regs.pending | (hit & regs.int_mask);
                r.event_pulses = hit & regs.event_mask;
                regs.last_levels = p;
            end
            REQ_WRITE: begin
                case (addr)
                    ADDR_IMASK:  regs.int_mask = d;
                    ADDR_EMASK:  regs.event_mask = d;
                    ADDR_RISE:   regs.rise_select = d;
                    ADDR_FALL:   regs.fall_select = d;
                    ADDR_SWTRIG: begin
                        fresh = d & ~regs.soft_trigger;
                        regs.pending = regs.pending | (fresh & regs.int_mask);
                        r.event_pulses = fresh & regs.event_mask;
                        regs.soft_trigger = regs.soft_trigger | d;
                    end
                    ADDR_PENDING: begin
                        regs.pending = regs.pending & ~d;
                        regs.soft_trigger = regs.soft_trigger & ~d;
                    end
                    default: r.addr_error = 1'b1;
                endcase
            end
            REQ_READ: begin
                case (addr)
                    ADDR_IMASK:   r.read_data = regs.int_mask;
                    ADDR_EMASK:   r.read_data = regs.event_mask;
                    ADDR_RISE:    r.read_data = regs.rise_select;
                    ADDR_FALL:    r.read_data = regs.fall_select;
                    ADDR_SWTRIG:  r.read_data = regs.soft_trigger;
                    ADDR_PENDING: r.read_data = regs.pending;
                    default:      r.addr_error = 1'b1;
                endcase
            end
            default: ;
        endcase
        r.irq_lines = regs.pending & regs.int_mask;
        return r;
    endfunction

    always @(posedge aclk) begin
        exti_result_t want;
        if (!aresetn) begin
            regs = '0;
            results_due.delete();
            mismatch_count = 0;
            results_owed <= 0;
        end else begin
            if (s_valid && s_ready) begin
                results_due.push_back(apply_beat(s_req_type, s_reg_addr,
                                                 s_write_data, s_pin_levels));
            end
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result beat with nothing owed", m_irq_lines, '0);
                end else begin
                    want = results_due.pop_front();
                    if (m_read_data !== want.read_data)
                        report_mismatch("read_data", m_read_data, want.read_data);
                    if (m_irq_lines !== want.irq_lines)
                        report_mismatch("irq_lines", m_irq_lines, want.irq_lines);
                    if (m_event_pulses !== want.event_pulses)
                        report_mismatch("event_pulses", m_event_pulses, want.event_pulses);
                    if (m_addr_error !== want.addr_error)
                        report_mismatch("addr_error", FIELD_W'(m_addr_error),
                                        FIELD_W'(want.addr_error));
                end
            end
            results_owed <= results_due.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the interrupt controller bench: drives ticks, register writes and
// reads with random gaps and backpressure, and gives the verdict from the
// mismatch count of the checker.
// ----------------------------------------------------------------------------
module tb;
    import exti_pkg::*;

    // Request type 3 has no enum member; the block must treat it as idle
    localparam logic [1:0] REQ_RESERVED = 2'd3;
    // Addresses past the register file
    localparam logic [2:0] ADDR_BAD_LO = 3'd6;
    localparam logic [2:0] ADDR_BAD_HI = 3'd7;

    localparam logic [FIELD_W-1:0] ALL_ONES = '1;
    localparam logic [FIELD_W-1:0] CHECKER  = 23'h2AAAAA;
    localparam logic [FIELD_W-1:0] CHECKER_N = 23'h555555;

    localparam int RANDOM_BEATS = 1950;
    localparam int SETTLE_CYCLES = 8;      // two-stage pipe plus margin
    localparam int HOLD_OFF_AT = 400;      // result beat after which m_ready drops
    localparam int HOLD_OFF_CYCLES = 150;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_req_type;
    logic [2:0]         s_reg_addr;
    logic [FIELD_W-1:0] s_write_data;
    logic [FIELD_W-1:0] s_pin_levels;
    logic               m_valid;
    logic               m_ready;
    logic [FIELD_W-1:0] m_read_data;
    logic [FIELD_W-1:0] m_irq_lines;
    logic [FIELD_W-1:0] m_event_pulses;
    logic               m_addr_error;

    int mismatch_count;
    int results_owed;

    // Sender pacing: when set, beats go back to back
    bit back_to_back;
    // Pin levels of the last tick, so some ticks can flip only a few lines
    logic [FIELD_W-1:0] prev_pins;

    external_interrupt_line_controller_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_reg_addr     (s_reg_addr),
        .s_write_data   (s_write_data),
        .s_pin_levels   (s_pin_levels),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_irq_lines    (m_irq_lines),
        .m_event_pulses (m_event_pulses),
        .m_addr_error   (m_addr_error)
    );

    exti_beat_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_reg_addr     (s_reg_addr),
        .s_write_data   (s_write_data),
        .s_pin_levels   (s_pin_levels),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_irq_lines    (m_irq_lines),
        .m_event_pulses (m_event_pulses),
        .m_addr_error   (m_addr_error),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Offers one beat and returns at the edge that accepts it. Valid is only
    // dropped when a gap is drawn, so back-to-back beats keep it high.
    task automatic send_beat(input logic [1:0] kind, input logic [2:0] addr,
                             input logic [FIELD_W-1:0] wdata,
                             input logic [FIELD_W-1:0] pins);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= kind;
        s_reg_addr   <= addr;
        s_write_data <= wdata;
        s_pin_levels <= pins;
        if (kind == REQ_TICK) prev_pins = pins;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Picks one random beat. Ticks dominate so that edges keep arriving;
    // register writes reshape the masks and selects often enough that the
    // edge logic sees many settings.
    task automatic send_random_beat();
        int pick;
        logic [FIELD_W-1:0] pins;
        logic [FIELD_W-1:0] flips;
        logic [2:0] addr;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            if ($urandom_range(0, 1) == 0) begin
                pins = FIELD_W'($urandom());
            end else begin
                // sparse toggles: isolated edges on a few lines
                flips = FIELD_W'($urandom() & $urandom() & $urandom());
                pins = prev_pins ^ flips;
            end
            send_beat(REQ_TICK, 3'($urandom()), FIELD_W'($urandom()), pins);
        end else if (pick < 75) begin
            if ($urandom_range(0, 19) == 0)
                addr = 3'($urandom_range(ADDR_BAD_LO, ADDR_BAD_HI));
            else
                addr = 3'($urandom_range(ADDR_IMASK, ADDR_PENDING));
            send_beat(REQ_WRITE, addr, FIELD_W'($urandom()), FIELD_W'($urandom()));
        end else if (pick < 95) begin
            addr = 3'($urandom_range(ADDR_IMASK, ADDR_BAD_HI));
            send_beat(REQ_READ, addr, FIELD_W'($urandom()), FIELD_W'($urandom()));
        end else begin
            send_beat(REQ_RESERVED, 3'($urandom()), FIELD_W'($urandom()),
                      FIELD_W'($urandom()));
        end
    endtask

    // Stimulus: reset, directed beats, random beats, drain, verdict
    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_req_type   <= REQ_TICK;
        s_reg_addr   <= ADDR_IMASK;
        s_write_data <= '0;
        s_pin_levels <= '0;
        back_to_back = 1'b0;
        prev_pins = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: register file at reset, then the extremes
        send_beat(REQ_READ,  ADDR_PENDING, '0, '0);
        send_beat(REQ_WRITE, ADDR_IMASK,   ALL_ONES, '0);
        send_beat(REQ_WRITE, ADDR_EMASK,   CHECKER, '0);
        send_beat(REQ_WRITE, ADDR_RISE,    ALL_ONES, '0);
        send_beat(REQ_WRITE, ADDR_FALL,    CHECKER_N, '0);
        // first tick compares against all-zero levels: every line rises
        send_beat(REQ_TICK,  ADDR_BAD_HI,  ALL_ONES, ALL_ONES);
        // everything falls, only the even-numbered lines are selected
        send_beat(REQ_TICK,  ADDR_IMASK,   '0, '0);
        send_beat(REQ_READ,  ADDR_PENDING, '0, ALL_ONES);
        send_beat(REQ_READ,  ADDR_IMASK,   '0, '0);
        send_beat(REQ_READ,  ADDR_EMASK,   '0, '0);
        send_beat(REQ_READ,  ADDR_RISE,    '0, '0);
        send_beat(REQ_READ,  ADDR_FALL,    '0, '0);
        // clear all pending, then soft trigger: first write fires, repeat does not
        send_beat(REQ_WRITE, ADDR_PENDING, ALL_ONES, '0);
        send_beat(REQ_WRITE, ADDR_SWTRIG,  ALL_ONES, '0);
        send_beat(REQ_WRITE, ADDR_SWTRIG,  ALL_ONES, '0);
        send_beat(REQ_WRITE, ADDR_SWTRIG,  '0, ALL_ONES);
        // partial clear drops soft trigger bits too
        send_beat(REQ_WRITE, ADDR_PENDING, CHECKER, '0);
        send_beat(REQ_READ,  ADDR_SWTRIG,  '0, '0);
        send_beat(REQ_WRITE, ADDR_SWTRIG,  ALL_ONES, '0);
        // bad addresses on both paths
        send_beat(REQ_WRITE, ADDR_BAD_LO,  ALL_ONES, '0);
        send_beat(REQ_READ,  ADDR_BAD_HI,  '0, '0);
        // reserved request: no state change, irq still reported
        send_beat(REQ_RESERVED, ADDR_BAD_HI, ALL_ONES, ALL_ONES);
        send_beat(REQ_WRITE, ADDR_EMASK,   ALL_ONES, '0);
        send_beat(REQ_TICK,  ADDR_PENDING, ALL_ONES, ALL_ONES);
        send_beat(REQ_WRITE, ADDR_IMASK,   '0, '0);

        // Random part; pacing switches between gapped and back-to-back runs
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 64 == 0) back_to_back = ($urandom_range(0, 3) == 0);
            send_random_beat();
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result side: random stalls per beat, stall-free stretches, and one long
    // hold-off mid run so the pipe fills and s_ready drops.
    initial begin
        int stall;
        int drained;
        bit no_stalls;
        bit held;
        m_ready <= 1'b0;
        drained = 0;
        no_stalls = 1'b0;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (drained % 64 == 0) no_stalls = ($urandom_range(0, 3) == 0);
            stall = no_stalls ? 0 : $urandom_range(0, 3);
            if (!held && drained >= HOLD_OFF_AT) begin
                held = 1'b1;
                stall = HOLD_OFF_CYCLES;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            drained++;
        end
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== external_interrupt_line_controller_unit.f =====
rtl/exti_pkg.sv
rtl/exti_core.sv
rtl/external_interrupt_line_controller_unit.sv
verif/exti_beat_checker.sv
verif/tb.sv
